// ===== rtl/ilu_pkg.sv =====
// Shared types, constants and fixed-point helpers for the iterative lens undistortion unit.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
package ilu_pkg;

  localparam int ILU_ITERATIONS = 5;
  localparam int FRAC_BITS      = 20;
  localparam int DIV_BITS       = 41;
  localparam int ITER_STAGES    = 8;

  typedef logic signed [31:0] word_t;

  typedef enum logic [2:0] {
    REG_FOCAL_X = 3'd0,
    REG_FOCAL_Y = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_K1 = 3'd4,
    REG_K2 = 3'd5,
    REG_P1 = 3'd6,
    REG_P2 = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [19:0] pixel_u;
    logic [19:0] pixel_v;
  } in_req_t;

  typedef struct packed {
    logic signed [23:0] norm_x;
    logic signed [23:0] norm_y;
    logic               saturated;
  } out_res_t;

  typedef struct packed {
    logic [23:0]         rem;
    logic [DIV_BITS-1:0] nq;
    logic                neg;
  } div_lane_t;

  typedef struct packed {
    div_lane_t x;
    div_lane_t y;
  } div_pair_t;

  typedef struct packed {
    word_t ex;
    word_t ey;
    word_t mx;
    word_t my;
  } est_t;

  typedef struct packed {
    logic signed [23:0] k1;
    logic signed [23:0] k2;
    logic signed [23:0] p1;
    logic signed [23:0] p2;
  } coef_t;

  localparam logic signed [47:0] W_MAX = 48'sd2147483647;
  localparam logic signed [47:0] W_MIN = -48'sd2147483648;
  localparam logic signed [47:0] ONE_Q20 = 48'sd1048576;

  function automatic logic signed [43:0] qround(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + 64'sd524288;
    return s[63:20];
  endfunction

  function automatic word_t clampw(input logic signed [47:0] v);
    if (v > W_MAX) return word_t'(W_MAX);
    if (v < W_MIN) return word_t'(W_MIN);
    return v[31:0];
  endfunction

endpackage

// ===== rtl/ilu_div_cell.sv =====
// One restoring-division cell: develops one quotient bit for both coordinates.
// Depends on ilu_pkg.
`timescale 1ns / 1ps
module ilu_div_cell
  import ilu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  div_pair_t   in_pair,
  input  logic [23:0] div_x,
  input  logic [23:0] div_y,
  output logic        out_valid,
  output div_pair_t   out_pair
);

  function automatic div_lane_t step(input div_lane_t l, input logic [23:0] d);
    div_lane_t  r;
    logic [24:0] t;
    logic        ge;
    t  = {l.rem, l.nq[DIV_BITS-1]};
    ge = t >= {1'b0, d};
    r.rem = ge ? 24'(t - {1'b0, d}) : t[23:0];
    r.nq  = {l.nq[DIV_BITS-2:0], ge};
    r.neg = l.neg;
    return r;
  endfunction

  logic      valid_r;
  div_pair_t pair_r;
  div_pair_t pair_nxt;

  assign pair_nxt.x = step(in_pair.x, div_x);
  assign pair_nxt.y = step(in_pair.y, div_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    pair_r <= pair_nxt;
  end

  assign out_valid = valid_r;
  assign out_pair  = pair_r;

endmodule

// ===== rtl/ilu_iter_cell.sv =====
// One undistortion iteration as an eight-stage pipeline of multiply and round/sum stages.
// Depends on ilu_pkg.
`timescale 1ns / 1ps
module ilu_iter_cell
  import ilu_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  est_t  in_est,
  input  coef_t coef,
  output logic  out_valid,
  output est_t  out_est
);

  logic [ITER_STAGES-1:0] v_r;

  est_t               a_est_r, b_est_r, c_est_r, d_est_r, e_est_r, f_est_r, g_est_r, h_est_r;
  logic signed [63:0] a_xx_r, a_yy_r, a_xy_r;
  word_t              b_r2_r, b_xy2_r, b_ax_r, b_ay_r;
  logic signed [63:0] c_rr_r, c_k1_r, c_p1x_r, c_p2x_r, c_p1y_r, c_p2y_r;
  word_t              d_r4_r;
  logic signed [43:0] d_k1r2_r, e_k1r2_r;
  logic signed [44:0] d_tx_r, d_ty_r, e_tx_r, e_ty_r, f_tx_r, f_ty_r, g_tx_r, g_ty_r;
  logic signed [63:0] e_k2_r;
  word_t              f_cd_r;
  logic signed [63:0] g_xc_r, g_yc_r;

  logic signed [63:0] a_xx_nxt, a_yy_nxt, a_xy_nxt;
  logic signed [43:0] xx, yy, xy;
  word_t              b_r2_nxt, b_xy2_nxt, b_ax_nxt, b_ay_nxt;
  logic signed [63:0] c_rr_nxt, c_k1_nxt, c_p1x_nxt, c_p2x_nxt, c_p1y_nxt, c_p2y_nxt;
  logic signed [63:0] e_k2_nxt, g_xc_nxt, g_yc_nxt;
  word_t              f_cd_nxt, dx, dy;
  est_t               h_est_nxt;

  always_comb begin
    a_xx_nxt = in_est.ex * in_est.ex;
    a_yy_nxt = in_est.ey * in_est.ey;
    a_xy_nxt = in_est.ex * in_est.ey;

    xx = qround(a_xx_r);
    yy = qround(a_yy_r);
    xy = qround(a_xy_r);
    b_xy2_nxt = clampw(48'(xy) + 48'(xy));
    b_r2_nxt  = clampw(48'(xx) + 48'(yy));
    b_ax_nxt  = clampw(48'(b_r2_nxt) + 48'(xx) + 48'(xx));
    b_ay_nxt  = clampw(48'(b_r2_nxt) + 48'(yy) + 48'(yy));

    c_rr_nxt  = b_r2_r * b_r2_r;
    c_k1_nxt  = coef.k1 * b_r2_r;
    c_p1x_nxt = coef.p1 * b_xy2_r;
    c_p2x_nxt = coef.p2 * b_ax_r;
    c_p1y_nxt = coef.p1 * b_ay_r;
    c_p2y_nxt = coef.p2 * b_xy2_r;

    e_k2_nxt = coef.k2 * d_r4_r;

    f_cd_nxt = clampw(ONE_Q20 + 48'(e_k1r2_r) + 48'(qround(e_k2_r)));

    g_xc_nxt = f_est_r.ex * f_cd_r;
    g_yc_nxt = f_est_r.ey * f_cd_r;

    dx = clampw(48'(qround(g_xc_r)) + 48'(g_tx_r));
    dy = clampw(48'(qround(g_yc_r)) + 48'(g_ty_r));
    h_est_nxt.ex = clampw(48'(g_est_r.ex) + 48'(g_est_r.mx) - 48'(dx));
    h_est_nxt.ey = clampw(48'(g_est_r.ey) + 48'(g_est_r.my) - 48'(dy));
    h_est_nxt.mx = g_est_r.mx;
    h_est_nxt.my = g_est_r.my;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[ITER_STAGES-2:0], in_valid};
    end
    a_est_r <= in_est;
    a_xx_r  <= a_xx_nxt;
    a_yy_r  <= a_yy_nxt;
    a_xy_r  <= a_xy_nxt;

    b_est_r <= a_est_r;
    b_r2_r  <= b_r2_nxt;
    b_xy2_r <= b_xy2_nxt;
    b_ax_r  <= b_ax_nxt;
    b_ay_r  <= b_ay_nxt;

    c_est_r <= b_est_r;
    c_rr_r  <= c_rr_nxt;
    c_k1_r  <= c_k1_nxt;
    c_p1x_r <= c_p1x_nxt;
    c_p2x_r <= c_p2x_nxt;
    c_p1y_r <= c_p1y_nxt;
    c_p2y_r <= c_p2y_nxt;

    d_est_r  <= c_est_r;
    d_r4_r   <= clampw(48'(qround(c_rr_r)));
    d_k1r2_r <= qround(c_k1_r);
    d_tx_r   <= 45'(qround(c_p1x_r)) + 45'(qround(c_p2x_r));
    d_ty_r   <= 45'(qround(c_p1y_r)) + 45'(qround(c_p2y_r));

    e_est_r  <= d_est_r;
    e_k2_r   <= e_k2_nxt;
    e_k1r2_r <= d_k1r2_r;
    e_tx_r   <= d_tx_r;
    e_ty_r   <= d_ty_r;

    f_est_r <= e_est_r;
    f_cd_r  <= f_cd_nxt;
    f_tx_r  <= e_tx_r;
    f_ty_r  <= e_ty_r;

    g_est_r <= f_est_r;
    g_xc_r  <= g_xc_nxt;
    g_yc_r  <= g_yc_nxt;
    g_tx_r  <= f_tx_r;
    g_ty_r  <= f_ty_r;

    h_est_r <= h_est_nxt;
  end

  assign out_valid = v_r[ITER_STAGES-1];
  assign out_est   = h_est_r;

endmodule

// ===== rtl/iterative_lens_undistortion_unit.sv =====
// Top level of the iterative lens undistortion unit: configuration registers,
// a row of division cells for normalization and a row of iteration cells.
// Depends on ilu_pkg, ilu_div_cell and ilu_iter_cell.
// Throughput: one request per clock; busy is low whenever reset is released.
// Data path: the input register, the 41 quotient-bit division cells, a normalization register,
// eight pipeline stages per iteration and the output register.
// Results cannot be stalled; each strobe lasts exactly one cycle.
// Synchronous reset clears all valid bits and restores the register defaults.
`timescale 1ns / 1ps
module iterative_lens_undistortion_unit
  import ilu_pkg::*;
#(
  parameter int ITERATIONS = ILU_ITERATIONS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  in_req_t     in_data,
  output logic        busy,
  output logic        out_valid,
  output out_res_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);

  logic [23:0] focal_x_r, focal_y_r;
  logic [19:0] center_x_r, center_y_r;
  coef_t       coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= 24'd131072;
      focal_y_r  <= 24'd131072;
      center_x_r <= 20'd81920;
      center_y_r <= 20'd61440;
      coef_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_FOCAL_X:  focal_x_r  <= cfg_wdata;
        REG_FOCAL_Y:  focal_y_r  <= cfg_wdata;
        REG_CENTER_X: center_x_r <= cfg_wdata[19:0];
        REG_CENTER_Y: center_y_r <= cfg_wdata[19:0];
        REG_K1:       coef_r.k1  <= cfg_wdata;
        REG_K2:       coef_r.k2  <= cfg_wdata;
        REG_P1:       coef_r.p1  <= cfg_wdata;
        REG_P2:       coef_r.p2  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = ~rst_n;

  logic    in_v_r;
  in_req_t in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= start && !busy;
    end
    in_r <= in_data;
  end

  logic [23:0] feff_x, feff_y;
  assign feff_x = (focal_x_r == '0) ? 24'd1 : focal_x_r;
  assign feff_y = (focal_y_r == '0) ? 24'd1 : focal_y_r;

  function automatic div_lane_t div_load(input logic [19:0] p, input logic [19:0] c,
                                         input logic [23:0] f);
    div_lane_t          l;
    logic signed [20:0] diff;
    logic [19:0]        mag;
    diff  = $signed({1'b0, p}) - $signed({1'b0, c});
    mag   = diff[20] ? 20'(-diff) : diff[19:0];
    l.rem = '0;
    l.nq  = {1'b0, mag, 20'd0} + DIV_BITS'(f >> 1);
    l.neg = diff[20];
    return l;
  endfunction

  function automatic word_t div_finish(input div_lane_t l);
    logic [DIV_BITS-1:0] q;
    q = l.nq;
    if (!l.neg) begin
      return (q > DIV_BITS'(32'h7fffffff)) ? word_t'(W_MAX) : q[31:0];
    end
    return (q > DIV_BITS'(32'h80000000)) ? word_t'(W_MIN) : 32'(-q[31:0]);
  endfunction

  logic      div_v [0:DIV_BITS];
  div_pair_t div_p [0:DIV_BITS];

  assign div_v[0]   = in_v_r;
  assign div_p[0].x = div_load(in_r.pixel_u, center_x_r, feff_x);
  assign div_p[0].y = div_load(in_r.pixel_v, center_y_r, feff_y);

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    ilu_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (div_v[k]),
      .in_pair   (div_p[k]),
      .div_x     (feff_x),
      .div_y     (feff_y),
      .out_valid (div_v[k+1]),
      .out_pair  (div_p[k+1])
    );
  end

  logic it_v [0:ITERATIONS];
  est_t it_e [0:ITERATIONS];
  logic norm_v_r;
  est_t norm_r;
  est_t norm_nxt;

  assign norm_nxt.mx = div_finish(div_p[DIV_BITS].x);
  assign norm_nxt.my = div_finish(div_p[DIV_BITS].y);
  assign norm_nxt.ex = norm_nxt.mx;
  assign norm_nxt.ey = norm_nxt.my;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_v_r <= 1'b0;
    end else begin
      norm_v_r <= div_v[DIV_BITS];
    end
    norm_r <= norm_nxt;
  end

  assign it_v[0] = norm_v_r;
  assign it_e[0] = norm_r;

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    ilu_iter_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (it_v[i]),
      .in_est    (it_e[i]),
      .coef      (coef_r),
      .out_valid (it_v[i+1]),
      .out_est   (it_e[i+1])
    );
  end

  logic     out_v_r;
  out_res_t out_r;
  out_res_t out_nxt;
  logic     sat_x, sat_y;

  always_comb begin
    word_t fx, fy;
    fx = it_e[ITERATIONS].ex;
    fy = it_e[ITERATIONS].ey;
    sat_x = (fx > 32'sd8388607) || (fx < -32'sd8388608);
    sat_y = (fy > 32'sd8388607) || (fy < -32'sd8388608);
    out_nxt.norm_x = sat_x ? (fx[31] ? -24'sd8388608 : 24'sd8388607) : fx[23:0];
    out_nxt.norm_y = sat_y ? (fy[31] ? -24'sd8388608 : 24'sd8388607) : fy[23:0];
    out_nxt.saturated = sat_x || sat_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= it_v[ITERATIONS];
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> in_v_r)
    else $error("accepted request did not enter the pipeline");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    div_v[DIV_BITS] |-> (div_p[DIV_BITS].x.rem < feff_x) && (div_p[DIV_BITS].y.rem < feff_y))
    else $error("division remainder not below divisor");

  a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.saturated) |->
      ($past(it_e[ITERATIONS].ex) == 32'(out_data.norm_x)) &&
      ($past(it_e[ITERATIONS].ey) == 32'(out_data.norm_y)))
    else $error("unsaturated result differs from final estimate");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule
